@@ sv/imad_pkg.sv @@
// ----------------------------------------------------------------------------
// imad_pkg: shared types and constants of the IMU motion alert detector
// Holds the item structures, the configuration set, register indexes, reason
// codes and the front-end sequencer states.
// ----------------------------------------------------------------------------
package imad_pkg;

  // Number of sensor sides tracked; the side field spans exactly this range.
  localparam int NUM_SIDES = 2;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GYRO_THR  = 3'd0,
    CFG_ACCEL_THR = 3'd1,
    CFG_GRAVITY   = 3'd2,
    CFG_DEBOUNCE  = 3'd3,
    CFG_COOLDOWN  = 3'd4,
    CFG_MIN_ALERT = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] RST_GYRO_THR  = 16'd1638;
  localparam logic [15:0] RST_ACCEL_THR = 16'd2048;
  localparam logic [15:0] RST_GRAVITY   = 16'd2511;
  localparam logic [15:0] RST_DEBOUNCE  = 16'd50;
  localparam logic [15:0] RST_COOLDOWN  = 16'd100;
  localparam logic [15:0] RST_MIN_ALERT = 16'd500;

  // Event reason codes.
  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_ACCEL     = 3'd1,
    RSN_GYRO      = 3'd2,
    RSN_BOTH      = 3'd3,
    RSN_RECOVERED = 3'd4
  } reason_e;

  // Front-end sequencer states.
  typedef enum logic [2:0] {
    FR_IDLE,
    FR_SQ,
    FR_ROOT,
    FR_CMP,
    FR_PUSH
  } front_state_e;

  typedef struct packed {
    logic [15:0] gyro_threshold;
    logic [15:0] accel_threshold;
    logic [15:0] gravity_level;
    logic [15:0] debounce_ms;
    logic [15:0] cooldown_ms;
    logic [15:0] min_alert_ms;
  } cfg_t;

  typedef struct packed {
    logic               side;
    logic [31:0]        time_ms;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic        event_side;
    logic        alert_on;
    logic [2:0]  reason;
    logic [15:0] gyro_magnitude;
    logic [15:0] accel_excess;
    logic [31:0] event_time_ms;
  } out_item_t;

  // Classified sample handed from the front to the back part.
  typedef struct packed {
    logic        side;
    logic [31:0] time_ms;
    logic [15:0] gyro_magnitude;
    logic [15:0] accel_excess;
    logic        over_g;
    logic        over_a;
  } cls_item_t;

  // Queue status seen by the producer, the consumer and the checks.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

@@ sv/imad_front.sv @@
// ----------------------------------------------------------------------------
// imad_front: sample intake and classification
// Squares the six axes on one shared multiplier, takes both floor square roots
// two bits a step, compares against the limits and queues the classified item.
// ----------------------------------------------------------------------------
module imad_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imad_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  imad_pkg::in_item_t   in_item_i,
  input  imad_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output imad_pkg::cls_item_t  push_item_o
);
  import imad_pkg::*;

  front_state_e state_q, state_d;
  logic [3:0]   cnt_q;
  in_item_t     item_q;
  logic [31:0]  acc_g_q, acc_a_q;
  logic [19:0]  rem_g_q, rem_a_q;
  logic [15:0]  root_g_q, root_a_q;
  cls_item_t    cls_q;

  logic signed [15:0] axis;
  logic signed [16:0] axis_x;
  logic [16:0]        axis_abs;
  logic [33:0]        axis_sq;
  logic [19:0]        remsh_g, remsh_a, trial_g, trial_a;
  logic [16:0]        exc_pos, exc_neg;
  logic [15:0]        excess;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (in_valid_i) state_d = FR_SQ;
      FR_SQ:   if (cnt_q == 4'd5) state_d = FR_ROOT;
      FR_ROOT: if (cnt_q == 4'd15) state_d = FR_CMP;
      FR_CMP:  state_d = FR_PUSH;
      FR_PUSH: if (!q_status_i.full) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_ready_o  = (state_q == FR_IDLE);
    push_o      = (state_q == FR_PUSH) && !q_status_i.full;
    push_item_o = cls_q;
  end

  // Axis select and square of its magnitude.
  always_comb begin
    case (cnt_q)
      4'd0:    axis = item_q.gyro_x;
      4'd1:    axis = item_q.gyro_y;
      4'd2:    axis = item_q.gyro_z;
      4'd3:    axis = item_q.accel_x;
      4'd4:    axis = item_q.accel_y;
      default: axis = item_q.accel_z;
    endcase
    axis_x   = {axis[15], axis};
    axis_abs = axis_x[16] ? 17'(-axis_x) : 17'(axis_x);
    axis_sq  = axis_abs * axis_abs;
  end

  // One digit step of each square root: bring down two radicand bits.
  always_comb begin
    remsh_g = {rem_g_q[17:0], acc_g_q[31:30]};
    remsh_a = {rem_a_q[17:0], acc_a_q[31:30]};
    trial_g = {2'b00, root_g_q, 2'b01};
    trial_a = {2'b00, root_a_q, 2'b01};
  end

  // Distance of the accel magnitude from the gravity reference.
  always_comb begin
    exc_pos = {1'b0, root_a_q} - {1'b0, cfg_i.gravity_level};
    exc_neg = {1'b0, cfg_i.gravity_level} - {1'b0, root_a_q};
    excess  = exc_pos[16] ? exc_neg[15:0] : exc_pos[15:0];
  end

  // Sequencer state and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else                    cnt_q <= cnt_q + 4'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      FR_IDLE: begin
        item_q  <= in_item_i;
        acc_g_q <= '0;
        acc_a_q <= '0;
      end
      FR_SQ: begin
        if (cnt_q < 4'd3) acc_g_q <= acc_g_q + axis_sq[31:0];
        else              acc_a_q <= acc_a_q + axis_sq[31:0];
        rem_g_q  <= '0;
        rem_a_q  <= '0;
        root_g_q <= '0;
        root_a_q <= '0;
      end
      FR_ROOT: begin
        acc_g_q <= {acc_g_q[29:0], 2'b00};
        acc_a_q <= {acc_a_q[29:0], 2'b00};
        if (remsh_g >= trial_g) begin
          rem_g_q  <= remsh_g - trial_g;
          root_g_q <= {root_g_q[14:0], 1'b1};
        end else begin
          rem_g_q  <= remsh_g;
          root_g_q <= {root_g_q[14:0], 1'b0};
        end
        if (remsh_a >= trial_a) begin
          rem_a_q  <= remsh_a - trial_a;
          root_a_q <= {root_a_q[14:0], 1'b1};
        end else begin
          rem_a_q  <= remsh_a;
          root_a_q <= {root_a_q[14:0], 1'b0};
        end
      end
      FR_CMP: begin
        cls_q.side           <= item_q.side;
        cls_q.time_ms        <= item_q.time_ms;
        cls_q.gyro_magnitude <= root_g_q;
        cls_q.accel_excess   <= excess;
        cls_q.over_g         <= (root_g_q >= cfg_i.gyro_threshold);
        cls_q.over_a         <= (excess >= cfg_i.accel_threshold);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/imad_fifo.sv @@
// ----------------------------------------------------------------------------
// imad_fifo: classified-item queue
// A small register queue that lets the front and back parts stall apart.
// ----------------------------------------------------------------------------
module imad_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  imad_pkg::cls_item_t  push_item_i,
  input  logic                 pop_i,
  output imad_pkg::cls_item_t  pop_item_o,
  output imad_pkg::q_status_t  status_o
);
  import imad_pkg::*;

  cls_item_t         mem_q [QDEPTH];
  logic [QIDX_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  // Status and head of the queue.
  always_comb begin
    status_o.count = cnt_q;
    status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
    status_o.empty = (cnt_q == '0);
    pop_item_o     = mem_q[rptr_q];
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_item_i;
  end

endmodule

@@ sv/imad_back.sv @@
// ----------------------------------------------------------------------------
// imad_back: per-side alert tracking
// Takes classified items from the queue, runs the debounce, cooldown and
// minimum-duration rules for each side and registers any event produced.
// ----------------------------------------------------------------------------
module imad_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imad_pkg::cfg_t       cfg_i,
  input  imad_pkg::q_status_t  q_status_i,
  input  imad_pkg::cls_item_t  q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output imad_pkg::out_item_t  out_item_o
);
  import imad_pkg::*;

  logic        act_q [NUM_SIDES];
  logic        osv_q [NUM_SIDES];
  logic [31:0] ost_q [NUM_SIDES];
  logic        tv_q  [NUM_SIDES];
  logic [31:0] tt_q  [NUM_SIDES];

  logic        out_valid_q;
  out_item_t   out_q;

  logic        over, activate, clear;
  logic [31:0] ost_new, d_over, d_trans;
  reason_e     reason;

  assign pop_o       = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Decision for the item at the head of the queue.
  always_comb begin
    over    = q_item_i.over_g || q_item_i.over_a;
    ost_new = osv_q[q_item_i.side] ? ost_q[q_item_i.side] : q_item_i.time_ms;
    d_over  = q_item_i.time_ms - ost_new;
    d_trans = q_item_i.time_ms - tt_q[q_item_i.side];
    if (q_item_i.over_a && q_item_i.over_g) reason = RSN_BOTH;
    else if (q_item_i.over_a)               reason = RSN_ACCEL;
    else                                    reason = RSN_GYRO;
    activate = over && !act_q[q_item_i.side] && (d_over >= 32'(cfg_i.debounce_ms)) &&
               (!tv_q[q_item_i.side] || (d_trans >= 32'(cfg_i.cooldown_ms)));
    clear    = !over && act_q[q_item_i.side] && (d_trans >= 32'(cfg_i.min_alert_ms));
  end

  // Per-side state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SIDES; i++) begin
        act_q[i] <= 1'b0;
        osv_q[i] <= 1'b0;
        ost_q[i] <= '0;
        tv_q[i]  <= 1'b0;
        tt_q[i]  <= '0;
      end
    end else begin
      if (pop_o) begin
        out_valid_q <= activate || clear;
        osv_q[q_item_i.side] <= over;
        ost_q[q_item_i.side] <= over ? ost_new : '0;
        if (activate || clear) begin
          act_q[q_item_i.side] <= activate;
          tv_q[q_item_i.side]  <= 1'b1;
          tt_q[q_item_i.side]  <= q_item_i.time_ms;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.event_side     <= q_item_i.side;
      out_q.alert_on       <= activate;
      out_q.reason         <= activate ? reason : RSN_RECOVERED;
      out_q.gyro_magnitude <= q_item_i.gyro_magnitude;
      out_q.accel_excess   <= q_item_i.accel_excess;
      out_q.event_time_ms  <= q_item_i.time_ms;
    end
  end

endmodule

@@ sv/imu_motion_alert_detector_top.sv @@
// ----------------------------------------------------------------------------
// imu_motion_alert_detector_top: IMU motion alert detector
// Front part classifies samples, a short queue decouples it from the back part
// that tracks alerts per side and emits transition events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one IMU sample
//   item per handshake. Output channel (out_valid_o / out_ready_i /
//   out_item_o) gives zero or one event item per sample, in sample order.
//   The configuration port writes register cfg_idx_i with cfg_wdata_i on any
//   edge with cfg_we_i high; write only while the block is idle.
//   Each sample passes through the front part in order: it is taken, its six
//   axes are squared on the shared multiplier, sixteen two-bit square root
//   steps follow, it is compared, and it enters the queue. The back part
//   pops a queued item once the output register is free or being read, and
//   registers its event. The front part takes a new sample only after it
//   has queued the previous one, so the front sequencer sets the throughput.
//   When the receiver stalls, the event waits in the output register and the
//   two-entry queue keeps filling; once it is full the front part holds its
//   item and stops taking samples.
//   Reset clears all alert state and restores the default register values.
// ----------------------------------------------------------------------------
module imu_motion_alert_detector_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  imad_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output imad_pkg::out_item_t  out_item_o
);
  import imad_pkg::*;

  cfg_t      cfg_q;
  logic      push, pop;
  cls_item_t push_item, pop_item;
  q_status_t q_status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_threshold  <= RST_GYRO_THR;
      cfg_q.accel_threshold <= RST_ACCEL_THR;
      cfg_q.gravity_level   <= RST_GRAVITY;
      cfg_q.debounce_ms     <= RST_DEBOUNCE;
      cfg_q.cooldown_ms     <= RST_COOLDOWN;
      cfg_q.min_alert_ms    <= RST_MIN_ALERT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GYRO_THR:  cfg_q.gyro_threshold  <= cfg_wdata_i;
        CFG_ACCEL_THR: cfg_q.accel_threshold <= cfg_wdata_i;
        CFG_GRAVITY:   cfg_q.gravity_level   <= cfg_wdata_i;
        CFG_DEBOUNCE:  cfg_q.debounce_ms     <= cfg_wdata_i;
        CFG_COOLDOWN:  cfg_q.cooldown_ms     <= cfg_wdata_i;
        CFG_MIN_ALERT: cfg_q.min_alert_ms    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  imad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  imad_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  imad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Checks.
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("push into a full queue");

  a_on_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.alert_on) |->
      (out_item_o.reason == RSN_ACCEL || out_item_o.reason == RSN_GYRO ||
       out_item_o.reason == RSN_BOTH))
    else $error("activation event with a bad reason");

  a_off_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.alert_on) |-> (out_item_o.reason == RSN_RECOVERED))
    else $error("clear event without the recovered reason");

endmodule
